// ----- sv/iev_pkg.sv -----
// Shared types and constants for the index entry variable-length encoder.
// No dependencies; imported by every module of the block.
package iev_pkg;

   // widths of the packed posting word and its byte count
   localparam int unsigned WordBits  = 72;
   localparam int unsigned CountBits = 4;

   // layout codes carried in the top two bits of the first byte
   localparam logic [1:0] FMT_3BYTE = 2'd0;
   localparam logic [1:0] FMT_4BYTE = 2'd1;
   localparam logic [1:0] FMT_5BYTE = 2'd2;
   localparam logic [1:0] FMT_9BYTE = 2'd3;

   // byte counts per layout
   localparam logic [CountBits-1:0] LEN_3BYTE = 4'd3;
   localparam logic [CountBits-1:0] LEN_4BYTE = 4'd4;
   localparam logic [CountBits-1:0] LEN_5BYTE = 4'd5;
   localparam logic [CountBits-1:0] LEN_9BYTE = 4'd9;
   localparam logic [CountBits-1:0] LEN_ERROR = 4'd1;

   // one posting as accepted on the request side
   typedef struct packed {
      logic [31:0] record_number;
      logic [15:0] field_number;
      logic [15:0] paragraph_number;
      logic [15:0] sentence_number;
      logic [15:0] word_position;
   } req_type;

   // one encoded byte as delivered on the response side
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic [1:0] format_code;
      logic       encode_error;
   } rsp_type;

   // classified posting, first byte in the top eight bits of the word
   typedef struct packed {
      logic [WordBits-1:0]  word;
      logic [CountBits-1:0] nbytes;
      logic [1:0]           code;
      logic                 error;
   } entry_type;

   // queue control driven by the serializer
   typedef struct packed {
      logic valid;
      logic pop;
   } qctl_type;

endpackage

// ----- sv/iev_front.sv -----
// Front end: checks the posting against the four layout limits and packs it.
// Depends on iev_pkg for the request and entry types.
module iev_front
   import iev_pkg::*;
(
   input  req_type   req,
   output entry_type entry
);

   logic fit0, fit1, fit2, fit3;

   // limit checks for each layout
   always_comb begin
      fit0 = (req.word_position < 16'd16) && (req.sentence_number < 16'd2) &&
             (req.paragraph_number < 16'd2) && (req.field_number < 16'd16) &&
             (req.record_number < 32'd4096);
      fit1 = (req.word_position < 16'd16) && (req.sentence_number < 16'd16) &&
             (req.paragraph_number < 16'd8) && (req.field_number < 16'd32) &&
             (req.record_number < 32'd16384);
      fit2 = (req.word_position < 16'd32) && (req.sentence_number < 16'd64) &&
             (req.paragraph_number < 16'd64) && (req.field_number < 16'd32) &&
             (req.record_number < 32'd65536);
      fit3 = (req.word_position < 16'd1024) && (req.sentence_number < 16'd2048) &&
             (req.paragraph_number < 16'd16384) && (req.field_number < 16'd256) &&
             (req.record_number < 32'd134217728);
   end

   // first layout that fits wins, packed msb first after the code bits
   always_comb begin
      entry = '0;
      priority if (fit0) begin
         entry.word   = {FMT_3BYTE, req.word_position[3:0], req.sentence_number[0],
                         req.paragraph_number[0], req.field_number[3:0],
                         req.record_number[11:0], 48'd0};
         entry.nbytes = LEN_3BYTE;
         entry.code   = FMT_3BYTE;
      end else if (fit1) begin
         entry.word   = {FMT_4BYTE, req.word_position[3:0], req.sentence_number[3:0],
                         req.paragraph_number[2:0], req.field_number[4:0],
                         req.record_number[13:0], 40'd0};
         entry.nbytes = LEN_4BYTE;
         entry.code   = FMT_4BYTE;
      end else if (fit2) begin
         entry.word   = {FMT_5BYTE, req.word_position[4:0], req.sentence_number[5:0],
                         req.paragraph_number[5:0], req.field_number[4:0],
                         req.record_number[15:0], 32'd0};
         entry.nbytes = LEN_5BYTE;
         entry.code   = FMT_5BYTE;
      end else if (fit3) begin
         entry.word   = {FMT_9BYTE, req.word_position[9:0], req.sentence_number[10:0],
                         req.paragraph_number[13:0], req.field_number[7:0],
                         req.record_number[26:0]};
         entry.nbytes = LEN_9BYTE;
         entry.code   = FMT_9BYTE;
      end else begin
         entry.word   = '0;
         entry.nbytes = LEN_ERROR;
         entry.code   = FMT_3BYTE;
         entry.error  = 1'b1;
      end
   end

endmodule

// ----- sv/iev_queue.sv -----
// Two-entry queue between the classifier and the byte serializer.
// Depends on iev_pkg for the entry and control types.
module iev_queue
   import iev_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type wr_entry,
   output logic      full,
   input  qctl_type  ctl_in,
   output entry_type rd_entry,
   output logic      valid
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   // status and pointer update
   always_comb begin
      full      = (count_ff == 2'd2);
      valid     = (count_ff != 2'd0);
      do_push   = push && !full;
      do_pop    = ctl_in.pop && valid;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      rd_entry  = slot_ff[rd_ptr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// ----- sv/iev_back.sv -----
// Back end: shifts a packed posting into an output register, one byte per cycle while that register is free or popped.
// Depends on iev_pkg for the entry, control and response types.
module iev_back
   import iev_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  entry_type entry,
   input  logic      entry_valid,
   output qctl_type  qctl,
   output rsp_type   rsp,
   output logic      out_valid,
   input  logic      out_pop
);

   logic [WordBits-1:0]  shift_ff, shift_in;
   logic [CountBits-1:0] left_ff, left_in;
   logic [1:0]           code_ff, code_in;
   logic                 error_ff, error_in;
   logic                 busy_ff, busy_in;
   logic                 ovalid_ff, ovalid_in;
   rsp_type              out_ff, out_in;
   logic                 can_out, load;

   // emit a byte when the output register is free, reload when idle or on the last byte
   always_comb begin
      can_out   = !ovalid_ff || out_pop;
      load      = entry_valid && (!busy_ff || (can_out && left_ff == 4'd1));
      qctl.valid = entry_valid;
      qctl.pop   = load;
      shift_in  = shift_ff;
      left_in   = left_ff;
      code_in   = code_ff;
      error_in  = error_ff;
      busy_in   = busy_ff;
      ovalid_in = ovalid_ff;
      out_in    = out_ff;
      if (can_out) begin
         ovalid_in = busy_ff;
         if (busy_ff) begin
            out_in.data_byte    = shift_ff[WordBits-1 -: 8];
            out_in.last_byte    = (left_ff == 4'd1);
            out_in.format_code  = code_ff;
            out_in.encode_error = error_ff;
            shift_in = {shift_ff[WordBits-9:0], 8'd0};
            left_in  = left_ff - 4'd1;
            busy_in  = (left_ff != 4'd1);
         end
      end
      if (load) begin
         shift_in = entry.word;
         left_in  = entry.nbytes;
         code_in  = entry.code;
         error_in = entry.error;
         busy_in  = 1'b1;
      end
      rsp       = out_ff;
      out_valid = ovalid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         busy_ff   <= busy_in;
         ovalid_ff <= ovalid_in;
         left_ff   <= left_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      code_ff  <= code_in;
      error_ff <= error_in;
      out_ff   <= out_in;
   end

endmodule

// ----- sv/index_entry_varlen_encoder.sv -----
// Index entry variable-length encoder: one posting in, 1 to 9 encoded bytes out.
// Path from push to the result ports: queue slot, serializer shift register, output register.
// Throughput: one byte per cycle while postings are queued and pop keeps up; a posting has
// 3, 4, 5 or 9 bytes, one for a posting that fits no layout.
// Reset: synchronous, active high; empties the queue, serializer and output.
// Depends on iev_pkg, iev_front, iev_queue and iev_back.
module index_entry_varlen_encoder
   import iev_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   entry_type front_entry;
   entry_type queue_entry;
   logic      queue_valid;
   qctl_type  queue_ctl;
   logic      out_valid;

   // classify and pack
   iev_front u_front (
      .req   (req_data),
      .entry (front_entry)
   );

   // decoupling queue
   iev_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (front_entry),
      .full     (full),
      .ctl_in   (queue_ctl),
      .rd_entry (queue_entry),
      .valid    (queue_valid)
   );

   // byte serializer
   iev_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry       (queue_entry),
      .entry_valid (queue_valid),
      .qctl        (queue_ctl),
      .rsp         (rsp_data),
      .out_valid   (out_valid),
      .out_pop     (pop)
   );

   assign empty = !out_valid;

   // an error transaction is a single zero byte with layout code zero
   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.encode_error) |->
         (rsp_data.last_byte && rsp_data.data_byte == 8'd0 &&
          rsp_data.format_code == FMT_3BYTE))
      else $error("error transaction is malformed");

   // after a non-final byte is taken, the next byte of the posting follows at once
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_data.last_byte) |=> !empty)
      else $error("gap inside a posting");

   // the layout code holds across the bytes of one posting
   a_code_holds: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_data.last_byte) |=>
         (rsp_data.format_code == $past(rsp_data.format_code)))
      else $error("layout code changed inside a posting");

   // a waiting byte stays until taken
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("result dropped while stalled");

endmodule

// ----- bench/iev_posting_checker.sv -----
// Checker for the index entry encoder: predicts the byte stream of each accepted
// posting and compares every popped byte against it. Depends on iev_pkg.
module iev_posting_checker
   import iev_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    full,
   input  req_type req_data,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_count
);

   // bytes still owed by the block, oldest first
   rsp_type expected_bytes[$];
   rsp_type want;

   // pick the smallest layout that holds every field and queue its bytes
   function automatic void predict_posting(input req_type p);
      logic [31:0] rec;
      logic [15:0] fld, par, sen, wrd;
      logic [7:0]  b [9];
      logic [1:0]  code;
      int          n;
      rsp_type     r;
      rec = p.record_number;
      fld = p.field_number;
      par = p.paragraph_number;
      sen = p.sentence_number;
      wrd = p.word_position;
      if (wrd < 16 && sen < 2 && par < 2 && fld < 16 && rec < 32'd4096) begin
         code = FMT_3BYTE;
         n    = 3;
         b[0] = {code, wrd[3:0], sen[0], par[0]};
         b[1] = {fld[3:0], rec[11:8]};
         b[2] = rec[7:0];
      end else if (wrd < 16 && sen < 16 && par < 8 && fld < 32 && rec < 32'd16384) begin
         code = FMT_4BYTE;
         n    = 4;
         b[0] = {code, wrd[3:0], sen[3:2]};
         b[1] = {sen[1:0], par[2:0], fld[4:2]};
         b[2] = {fld[1:0], rec[13:8]};
         b[3] = rec[7:0];
      end else if (wrd < 32 && sen < 64 && par < 64 && fld < 32 && rec < 32'd65536) begin
         code = FMT_5BYTE;
         n    = 5;
         b[0] = {code, wrd[4:0], sen[5]};
         b[1] = {sen[4:0], par[5:3]};
         b[2] = {par[2:0], fld[4:0]};
         b[3] = rec[15:8];
         b[4] = rec[7:0];
      end else if (wrd < 1024 && sen < 2048 && par < 16384 && fld < 256 &&
                   rec < 32'd134217728) begin
         code = FMT_9BYTE;
         n    = 9;
         b[0] = {code, wrd[9:4]};
         b[1] = {wrd[3:0], sen[10:7]};
         b[2] = {sen[6:0], par[13]};
         b[3] = par[12:5];
         b[4] = {par[4:0], fld[7:5]};
         b[5] = {fld[4:0], rec[26:24]};
         b[6] = rec[23:16];
         b[7] = rec[15:8];
         b[8] = rec[7:0];
      end else begin
         // fits no layout: one flagged byte
         r.data_byte    = 8'h00;
         r.last_byte    = 1'b1;
         r.format_code  = FMT_3BYTE;
         r.encode_error = 1'b1;
         expected_bytes.push_back(r);
         return;
      end
      for (int k = 0; k < n; k++) begin
         r.data_byte    = b[k];
         r.last_byte    = (k == n - 1);
         r.format_code  = code;
         r.encode_error = 1'b0;
         expected_bytes.push_back(r);
      end
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         expected_bytes.delete();
      end else begin
         if (push && !full)
            predict_posting(req_data);
         if (pop && !empty) begin
            if (expected_bytes.size() == 0) begin
               $error("byte with no transaction pending: %h", rsp_data);
               error_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_data.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %h, got %h", want.data_byte, rsp_data.data_byte);
                  error_count++;
               end
               if (rsp_data.last_byte !== want.last_byte) begin
                  $error("last_byte: expected %b, got %b", want.last_byte, rsp_data.last_byte);
                  error_count++;
               end
               if (rsp_data.format_code !== want.format_code) begin
                  $error("format_code: expected %0d, got %0d",
                         want.format_code, rsp_data.format_code);
                  error_count++;
               end
               if (rsp_data.encode_error !== want.encode_error) begin
                  $error("encode_error: expected %b, got %b",
                         want.encode_error, rsp_data.encode_error);
                  error_count++;
               end
            end
         end
      end
      pending_count = expected_bytes.size();
   end

endmodule

// ----- bench/tb_index_entry_varlen_encoder.sv -----
// Testbench top for index_entry_varlen_encoder: drives directed and random postings,
// pops bytes with random stalls and a long hold-off. Depends on iev_pkg, the block
// and iev_posting_checker.
module tb_index_entry_varlen_encoder;
   import iev_pkg::*;

   localparam int ClockPeriod   = 12;
   localparam int ItemsPerPhase = 120;
   localparam int HoldCycles    = 250;
   localparam int DrainCycles   = 20;
   localparam int LimitCycles   = 400000;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   int      error_count;
   int      pending_count;
   int      tx_idle_pct;
   int      rx_idle_pct;
   logic    hold_request;

   index_entry_varlen_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   iev_posting_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .empty         (empty),
      .pop           (pop),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #(ClockPeriod * LimitCycles);
      $display("tb_index_entry_varlen_encoder: done, errors");
      $finish;
   end

   function automatic req_type make_posting(input logic [31:0] rec, input logic [15:0] fld,
                                            input logic [15:0] par, input logic [15:0] sen,
                                            input logic [15:0] wrd);
      req_type p;
      p.record_number    = rec;
      p.field_number     = fld;
      p.paragraph_number = par;
      p.sentence_number  = sen;
      p.word_position    = wrd;
      return p;
   endfunction

   // value below a layout limit, leaning on zero and the top value
   function automatic logic [31:0] pick_below(input int unsigned lim);
      int unsigned roll;
      roll = $urandom_range(7);
      if (roll == 0)
         return 32'd0;
      if (roll == 1)
         return lim - 1;
      return $urandom_range(lim - 1, 0);
   endfunction

   // mostly postings within a chosen layout, some with one field too wide, some noise
   function automatic req_type random_posting();
      req_type     p;
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 18)
         p = make_posting(pick_below(4096), 16'(pick_below(16)), 16'(pick_below(2)),
                          16'(pick_below(2)), 16'(pick_below(16)));
      else if (sel < 36)
         p = make_posting(pick_below(16384), 16'(pick_below(32)), 16'(pick_below(8)),
                          16'(pick_below(16)), 16'(pick_below(16)));
      else if (sel < 54)
         p = make_posting(pick_below(65536), 16'(pick_below(32)), 16'(pick_below(64)),
                          16'(pick_below(64)), 16'(pick_below(32)));
      else if (sel < 80)
         p = make_posting(pick_below(134217728), 16'(pick_below(256)),
                          16'(pick_below(16384)), 16'(pick_below(2048)),
                          16'(pick_below(1024)));
      else begin
         p = make_posting(pick_below(134217728), 16'(pick_below(256)),
                          16'(pick_below(16384)), 16'(pick_below(2048)),
                          16'(pick_below(1024)));
         if (sel < 92) begin
            // exactly one field past the widest layout
            case ($urandom_range(4))
               0: p.record_number    = $urandom_range(32'hFFFF_FFFF, 32'd134217728);
               1: p.field_number     = 16'($urandom_range(65535, 256));
               2: p.paragraph_number = 16'($urandom_range(65535, 16384));
               3: p.sentence_number  = 16'($urandom_range(65535, 2048));
               default: p.word_position = 16'($urandom_range(65535, 1024));
            endcase
         end else begin
            p.record_number    = $urandom;
            p.field_number     = 16'($urandom_range(65535));
            p.paragraph_number = 16'($urandom_range(65535));
            p.sentence_number  = 16'($urandom_range(65535));
            p.word_position    = 16'($urandom_range(65535));
         end
      end
      return p;
   endfunction

   // offer one posting, holding it until a transaction happens
   task automatic send_posting(input req_type p);
      logic stalled;
      while ($urandom_range(99) < tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= p;
      stalled = 1'b1;
      while (stalled) begin
         @(negedge clock);
         stalled = full;
         @(posedge clock);
      end
   endtask

   // receiver: random pops, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
         end else begin
            pop <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset        = 1'b1;
      push         = 1'b0;
      req_data     = '0;
      tx_idle_pct  = 27;
      rx_idle_pct  = 87;
      hold_request = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // layout boundaries, widest values and each way of overflowing
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'd4095, 16'd15, 16'd1, 16'd1, 16'd15));
      send_posting(make_posting(32'd4096, 16'd0, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'd0, 16'd0, 16'd2, 16'd0, 16'd0));
      send_posting(make_posting(32'd16383, 16'd31, 16'd7, 16'd15, 16'd15));
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd0, 16'd16));
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd16, 16'd0));
      send_posting(make_posting(32'd65535, 16'd31, 16'd63, 16'd63, 16'd31));
      send_posting(make_posting(32'd0, 16'd32, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'd65536, 16'd0, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'd134217727, 16'd255, 16'd16383, 16'd2047, 16'd1023));
      send_posting(make_posting(32'h0555_5555, 16'h00AA, 16'h2AAA, 16'h0555, 16'h02AA));
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd0, 16'd1023));
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd2047, 16'd0));
      send_posting(make_posting(32'd0, 16'd0, 16'd16383, 16'd0, 16'd0));
      send_posting(make_posting(32'd134217728, 16'd0, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'd0, 16'd256, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'd0, 16'd0, 16'd16384, 16'd0, 16'd0));
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd2048, 16'd0));
      send_posting(make_posting(32'd0, 16'd0, 16'd0, 16'd0, 16'd1024));
      send_posting(make_posting(32'hFFFF_FFFF, 16'd0, 16'd0, 16'd0, 16'd0));
      send_posting(make_posting(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));

      // random postings in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 27;
               rx_idle_pct = 87;
            end
            1: begin
               tx_idle_pct = 87;
               rx_idle_pct = 27;
            end
            default: begin
               tx_idle_pct  = 0;
               rx_idle_pct  = 0;
               hold_request = 1'b1;
            end
         endcase
         repeat (ItemsPerPhase) send_posting(random_posting());
      end
      push <= 1'b0;

      // drain
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb_index_entry_varlen_encoder: done, clean");
      else
         $display("tb_index_entry_varlen_encoder: done, errors");
      $finish;
   end

endmodule

// ----- index_entry_varlen_encoder.f -----
sv/iev_pkg.sv
sv/iev_front.sv
sv/iev_queue.sv
sv/iev_back.sv
sv/index_entry_varlen_encoder.sv
bench/iev_posting_checker.sv
bench/tb_index_entry_varlen_encoder.sv
